// ===== hdl/rpr_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// random-replacement page store. No dependencies.
`timescale 1ns / 1ps

package rpr_pkg;

	localparam int DEF_MAX_FRAMES = 16;
	localparam int DEF_PAGE_BITS  = 20;

	localparam int PAGE_W  = 20;
	localparam int DRAW_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int FAULT_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

	typedef struct packed {
		logic start;
		logic scan;
		logic fill;
		logic mod_start;
		logic mod_step;
		logic vic_read;
		logic vic_write;
		logic finish;
	} rpr_cmd_t;

	typedef struct packed {
		logic issue_done;
		logic rd_busy;
		logic hit;
		logic room;
		logic mod_done;
		logic out_free;
	} rpr_sts_t;

endpackage

// ===== hdl/rpr_ctrl.sv =====
// Sequencing state machine for the page store: lookup scan, fill or
// victim selection, result hand-off. Depends on rpr_pkg.
`timescale 1ns / 1ps

module rpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rpr_pkg::rpr_sts_t sts,
	output rpr_pkg::rpr_cmd_t cmd
);
	import rpr_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_MOD    = 7'b0001000,
		ST_VRD    = 7'b0010000,
		ST_VWR    = 7'b0100000,
		ST_FIN    = 7'b1000000
	} rpr_state_t;

	rpr_state_t state_q;
	rpr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = !sts.issue_done;
				if (sts.issue_done && !sts.rd_busy) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.hit) begin
					state_d = ST_FIN;
				end else if (sts.room) begin
					cmd.fill = 1'b1;
					state_d  = ST_FIN;
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = ST_MOD;
				end
			end
			ST_MOD: begin
				if (sts.mod_done) begin
					state_d = ST_VRD;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			ST_VRD: begin
				cmd.vic_read = 1'b1;
				state_d      = ST_VWR;
			end
			ST_VWR: begin
				cmd.vic_write = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rpr_dp.sv =====
// Datapath of the page store: frame memory, scan compare, bit-serial
// modulo for victim choice, counters and result register. Uses rpr_pkg.
`timescale 1ns / 1ps

module rpr_dp #(
	parameter int MAX_FRAMES = rpr_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BITS  = rpr_pkg::DEF_PAGE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rpr_pkg::rpr_cmd_t           cmd,
	output rpr_pkg::rpr_sts_t           sts,
	input  logic                        cfg_valid,
	input  logic [rpr_pkg::CAP_W-1:0]   capacity,
	input  logic [rpr_pkg::PAGE_W-1:0]  page_number,
	input  logic [rpr_pkg::DRAW_W-1:0]  random_draw,
	input  logic                        end_of_trace,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic                        evicted_valid,
	output logic [rpr_pkg::PAGE_W-1:0]  evicted_page,
	output logic [rpr_pkg::SLOT_W-1:0]  slot_used,
	output logic [rpr_pkg::FAULT_W-1:0] fault_count
);
	import rpr_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int EC_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int MC_W  = $clog2(DRAW_W + 1);

	logic [PAGE_BITS-1:0] mem [MAX_FRAMES];

	logic [PAGE_BITS-1:0] page_in;
	logic [PAGE_BITS-1:0] page_q;
	logic [DRAW_W-1:0]    draw_q;
	logic                 last_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     held_q;
	logic [FAULT_W-1:0]   fault_q;
	logic [CAP_W-1:0]     capacity_q;
	logic                 hit_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [IDX_W-1:0]     slot_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DRAW_W-1:0]    dshift_q;
	logic [MC_W-1:0]      mcnt_q;

	logic [PAGE_BITS-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	logic                 out_valid_q;
	logic                 hit_o_q;
	logic                 ev_valid_o_q;
	logic [PAGE_BITS-1:0] ev_page_o_q;
	logic [IDX_W-1:0]     slot_o_q;
	logic [FAULT_W-1:0]   fault_o_q;

	logic [EC_W-1:0]      cap_ext;
	logic [EC_W-1:0]      eff_cap;
	logic [CNT_W:0]       trial;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic                 match;
	logic [FAULT_W-1:0]   fault_inc;

	for (genvar g = 0; g < PAGE_BITS; g++) begin : g_pin
		if (g < PAGE_W) begin : g_b
			assign page_in[g] = page_number[g];
		end else begin : g_z
			assign page_in[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < PAGE_W; g++) begin : g_pout
		if (g < PAGE_BITS) begin : g_b
			assign evicted_page[g] = ev_page_o_q[g];
		end else begin : g_z
			assign evicted_page[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < SLOT_W; g++) begin : g_sout
		if (g < IDX_W) begin : g_b
			assign slot_used[g] = slot_o_q[g];
		end else begin : g_z
			assign slot_used[g] = 1'b0;
		end
	end

	// effective capacity: zero reads as one, clipped at the frame count
	always_comb begin
		cap_ext = EC_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = EC_W'(1);
		end else if (cap_ext > EC_W'(MAX_FRAMES)) begin
			eff_cap = EC_W'(MAX_FRAMES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign trial     = {rem_q, dshift_q[DRAW_W-1]};
	assign rd_en     = cmd.scan || cmd.vic_read;
	assign rd_addr   = cmd.vic_read ? rem_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wr_en     = cmd.fill || cmd.vic_write;
	assign wr_addr   = cmd.vic_write ? rem_q[IDX_W-1:0] : held_q[IDX_W-1:0];
	assign match     = rd_vld_s1 && (rd_data_s1 == page_q) && !hit_q;
	assign fault_inc = (fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);

	assign sts.issue_done = (idx_q >= held_q);
	assign sts.rd_busy    = rd_vld_s1;
	assign sts.hit        = hit_q;
	assign sts.room       = (EC_W'(held_q) < eff_cap);
	assign sts.mod_done   = (mcnt_q == MC_W'(DRAW_W));
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= page_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			fault_q     <= '0;
			capacity_q  <= CAP_RESET;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= capacity;
			end
			rd_vld_s1 <= cmd.scan;
			if (cmd.fill) begin
				held_q  <= held_q + CNT_W'(1);
				fault_q <= fault_inc;
			end
			if (cmd.vic_write) begin
				fault_q <= fault_inc;
			end
			if (cmd.finish && last_q) begin
				held_q  <= '0;
				fault_q <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q     <= page_in;
			draw_q     <= random_draw;
			last_q     <= end_of_trace;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			ev_valid_q <= 1'b0;
			ev_page_q  <= '0;
			slot_q     <= '0;
		end
		if (cmd.scan) begin
			idx_q     <= idx_q + CNT_W'(1);
			rd_idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (match) begin
			hit_q  <= 1'b1;
			slot_q <= rd_idx_s1;
		end
		if (cmd.fill) begin
			slot_q <= held_q[IDX_W-1:0];
		end
		// restoring remainder, one draw bit a cycle
		if (cmd.mod_start) begin
			rem_q    <= '0;
			dshift_q <= draw_q;
			mcnt_q   <= '0;
		end
		if (cmd.mod_step) begin
			if (trial >= {1'b0, held_q}) begin
				rem_q <= CNT_W'(trial - {1'b0, held_q});
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
			dshift_q <= dshift_q << 1;
			mcnt_q   <= mcnt_q + MC_W'(1);
		end
		if (cmd.vic_write) begin
			ev_valid_q <= 1'b1;
			ev_page_q  <= rd_data_s1;
			slot_q     <= rem_q[IDX_W-1:0];
		end
		if (cmd.finish) begin
			hit_o_q      <= hit_q;
			ev_valid_o_q <= ev_valid_q;
			ev_page_o_q  <= ev_page_q;
			slot_o_q     <= slot_q;
			fault_o_q    <= fault_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_o_q;
	assign evicted_valid = ev_valid_o_q;
	assign fault_count   = fault_o_q;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(MAX_FRAMES))
		else $error("pages held beyond frame count");

	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vic_read |-> (rem_q < held_q))
		else $error("victim slot outside held pages");

	a_no_fill_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill || cmd.mod_start) |-> !hit_q)
		else $error("load issued for a resident page");

	a_fault_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!($past(cmd.finish) && $past(last_q)) |-> (fault_q >= $past(fault_q)))
		else $error("fault count dropped without end of trace");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_o_q && ev_valid_o_q))
		else $error("eviction reported on a hit");
`endif

endmodule

// ===== hdl/random_page_replacement_top.sv =====
// Random-replacement page store: a hit or a fill scans the pages held and then
// hands the result on; a replacement adds the bit-serial draw modulo (16 steps)
// and the victim read and write.
// Lookup scans one frame per cycle through the single read port. One item at a
// time; the next is taken once the result is in the output register.
// Reset clears pages held, fault count, capacity (to 4); frames need no clear.
`timescale 1ns / 1ps

module random_page_replacement_top #(
	parameter int MAX_FRAMES = rpr_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BITS  = rpr_pkg::DEF_PAGE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rpr_pkg::CAP_W-1:0]   capacity,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rpr_pkg::PAGE_W-1:0]  page_number,
	input  logic [rpr_pkg::DRAW_W-1:0]  random_draw,
	input  logic                        end_of_trace,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic                        evicted_valid,
	output logic [rpr_pkg::PAGE_W-1:0]  evicted_page,
	output logic [rpr_pkg::SLOT_W-1:0]  slot_used,
	output logic [rpr_pkg::FAULT_W-1:0] fault_count
);
	import rpr_pkg::*;

	rpr_cmd_t cmd;
	rpr_sts_t sts;

	// register writes only land while idle
	assign cfg_ready = !in_stall;

	rpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpr_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid && cfg_ready),
		.capacity      (capacity),
		.page_number   (page_number),
		.random_draw   (random_draw),
		.end_of_trace  (end_of_trace),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.slot_used     (slot_used),
		.fault_count   (fault_count)
	);

endmodule

// ===== test/tb_random_page_replacement_top.sv =====
// Self-checking testbench for random_page_replacement_top: directed and random page
// requests, with capacity changes between phases. The scoreboard predicts every result.
// Depends on rpr_pkg and random_page_replacement_top.
`timescale 1ns / 1ps

module tb_random_page_replacement_top;

	import rpr_pkg::*;

	localparam int FRAMES     = DEF_MAX_FRAMES;
	localparam int LIMIT      = 1500000;
	localparam int SETTLE     = 60;
	localparam int RAND_ITEMS = 1030;

	typedef struct packed {
		logic               hit;
		logic               ev_valid;
		logic [PAGE_W-1:0]  ev_page;
		logic [SLOT_W-1:0]  slot;
		logic [FAULT_W-1:0] faults;
	} page_result_t;

	class page_scoreboard;
		bit [PAGE_W-1:0]  frames [FRAMES];
		int unsigned      held;
		bit [FAULT_W-1:0] faults;
		bit [CAP_W-1:0]   cap;
		page_result_t     expected_q [$];
		int unsigned      mismatches;
		int unsigned      n_hits;
		int unsigned      n_evicts;
		int unsigned      n_clears;
		int unsigned      n_requests;

		function new();
			held = 0;
			faults = '0;
			cap = CAP_RESET;
			mismatches = 0;
			n_hits = 0;
			n_evicts = 0;
			n_clears = 0;
			n_requests = 0;
		endfunction

		function void set_capacity(bit [CAP_W-1:0] v);
			cap = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_request(bit [PAGE_W-1:0] page, bit [DRAW_W-1:0] draw, bit eot);
			page_result_t r;
			int unsigned  lim;
			int unsigned  i;
			int unsigned  v;
			bit           found;
			r = '0;
			found = 1'b0;
			lim = (cap == 0) ? 1 : ((cap > FRAMES) ? FRAMES : cap);
			for (i = 0; i < held; i++)
				if (!found && frames[i] == page) begin
					found = 1'b1;
					r.slot = i[SLOT_W-1:0];
				end
			r.hit = found;
			n_requests++;
			if (found) begin
				n_hits++;
			end else begin
				if (held < lim) begin
					r.slot = held[SLOT_W-1:0];
					frames[held] = page;
					held++;
				end else begin
					v = draw % held;
					r.slot = v[SLOT_W-1:0];
					r.ev_valid = 1'b1;
					r.ev_page = frames[v];
					frames[v] = page;
					n_evicts++;
				end
				if (faults != '1)
					faults++;
			end
			r.faults = faults;
			expected_q = {expected_q, r};
			if (eot) begin
				held = 0;
				faults = '0;
				n_clears++;
			end
		endfunction

		function void check_result(page_result_t got);
			page_result_t exp;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %p", $realtime, got);
				return;
			end
			exp = expected_q.pop_front();
			if (got.hit !== exp.hit || got.ev_valid !== exp.ev_valid ||
			    got.ev_page !== exp.ev_page || got.slot !== exp.slot ||
			    got.faults !== exp.faults) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: exp/got hit %b/%b ev %b/%b pg %h/%h slot %0d/%0d flt %0d/%0d",
						$realtime, exp.hit, got.hit, exp.ev_valid, got.ev_valid,
						exp.ev_page, got.ev_page, exp.slot, got.slot, exp.faults, got.faults);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_W-1:0]    capacity;
	logic                in_valid;
	logic                in_stall;
	logic [PAGE_W-1:0]   page_number;
	logic [DRAW_W-1:0]   random_draw;
	logic                end_of_trace;
	logic                out_valid;
	logic                out_stall;
	logic                hit;
	logic                evicted_valid;
	logic [PAGE_W-1:0]   evicted_page;
	logic [SLOT_W-1:0]   slot_used;
	logic [FAULT_W-1:0]  fault_count;

	page_scoreboard      sb;
	bit                  no_idle;
	int unsigned         cycle_count;
	int unsigned         n_settings;
	bit [PAGE_W-1:0]     pool [$];

	random_page_replacement_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.capacity     (capacity),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_number  (page_number),
		.random_draw  (random_draw),
		.end_of_trace (end_of_trace),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.slot_used    (slot_used),
		.fault_count  (fault_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 70);
	endfunction

	// receiver back-pressure
	initial begin
		int stall_len;
		int run_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (no_idle) begin
				out_stall = 1'b0;
				@(negedge clk);
			end else begin
				stall_len = pick_gap();
				run_len = $urandom_range(1, 8);
				if (stall_len > 0) begin
					out_stall = 1'b1;
					repeat (stall_len) @(negedge clk);
				end
				out_stall = 1'b0;
				repeat (run_len) @(negedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && sb != null && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result({hit, evicted_valid, evicted_page, slot_used, fault_count});

	task automatic send_request(bit [PAGE_W-1:0] page, bit [DRAW_W-1:0] draw, bit eot);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		page_number = page;
		random_draw = draw;
		end_of_trace = eot;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(page, draw, eot);
		@(negedge clk);
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(bit [CAP_W-1:0] v);
		drain();
		capacity = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_capacity(v);
		n_settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
		repeat (2) @(negedge clk);
	endtask

	function automatic bit [DRAW_W-1:0] pick_draw();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return DRAW_W'($urandom_range(0, 16'hFFFF));
	endfunction

	initial begin
		bit [CAP_W-1:0] caps [$];
		int             per_phase;
		int             lim;
		int             pool_size;
		int             k;
		int             p;
		bit [PAGE_W-1:0] page;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		capacity = CAP_RESET;
		in_valid = 1'b0;
		page_number = '0;
		random_draw = '0;
		end_of_trace = 1'b0;
		no_idle = 1'b0;
		n_settings = 0;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: fills, hits, replacement at both draw extremes, clear
		send_request(20'h00000, 16'h0000, 1'b0);
		send_request(20'hFFFFF, 16'hFFFF, 1'b0);
		send_request(20'h00000, 16'h1234, 1'b0);
		send_request(20'h12345, 16'h0000, 1'b0);
		send_request(20'hABCDE, 16'h0000, 1'b0);
		send_request(20'h55555, 16'hFFFF, 1'b0);
		send_request(20'hAAAAA, 16'h0000, 1'b0);
		send_request(20'hFFFFF, 16'h0000, 1'b0);
		send_request(20'h0F0F0, 16'h0005, 1'b1);
		send_request(20'h0F0F0, 16'h0005, 1'b0);
		send_request(20'h00001, 16'h0000, 1'b0);
		send_request(20'h00002, 16'h0000, 1'b0);
		send_request(20'h00003, 16'h0000, 1'b0);
		// capacity below pages held: store keeps its size
		write_capacity(5'd2);
		send_request(20'h00004, 16'h0007, 1'b0);
		send_request(20'h00002, 16'h0000, 1'b0);
		send_request(20'h00005, 16'hFFFE, 1'b1);
		// capacity zero acts as one frame
		write_capacity(5'd0);
		send_request(20'hC3C3C, 16'h0000, 1'b0);
		send_request(20'h3C3C3, 16'hFFFF, 1'b0);
		send_request(20'h3C3C3, 16'h0000, 1'b1);

		// random phases; capacity 31 and 17 are clipped to the frame count
		caps = '{5'd16, 5'd31, 5'd1, 5'd3, 5'd8, 5'd0, 5'd5, 5'd17, 5'd12, 5'd2, 5'd4};
		per_phase = RAND_ITEMS / caps.size();
		foreach (caps[ph]) begin
			write_capacity(caps[ph]);
			no_idle = (ph % 5 == 2);
			lim = (caps[ph] == 0) ? 1 : ((caps[ph] > FRAMES) ? FRAMES : caps[ph]);
			pool_size = lim + $urandom_range(0, lim + 2);
			pool.delete();
			for (k = 0; k < pool_size; k++) begin
				page = PAGE_W'($urandom_range(0, 20'hFFFFF));
				pool = {pool, page};
			end
			for (k = 0; k < per_phase; k++) begin
				p = $urandom_range(0, 99);
				if (p < 85)
					page = pool[$urandom_range(0, pool.size() - 1)];
				else if (p < 90)
					page = $urandom_range(0, 1) ? '1 : '0;
				else
					page = PAGE_W'($urandom_range(0, 20'hFFFFF));
				send_request(page, pick_draw(), $urandom_range(0, 49) == 0);
			end
		end
		no_idle = 1'b0;

		drain();
		$display("Ran %0d requests across %0d capacity values: %0d hits, %0d evictions,",
			sb.n_requests, n_settings, sb.n_hits, sb.n_evicts);
		$display("%0d trace resets; result mismatches: %0d", sb.n_clears, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rpr_pkg.sv
hdl/rpr_ctrl.sv
hdl/rpr_dp.sv
hdl/random_page_replacement_top.sv
test/tb_random_page_replacement_top.sv
